>>> hdl/rc_pkg.sv
package rc_pkg;

  localparam int RADIX_W = 5;
  localparam int CHAR_W  = 8;
  localparam int STAT_W  = 2;

  localparam logic [CHAR_W-1:0] CHAR_0 = 8'h30;  // '0'
  localparam logic [CHAR_W-1:0] CHAR_9 = 8'h39;  // '9'
  localparam logic [CHAR_W-1:0] CHAR_A = 8'h41;  // 'A'
  localparam logic [CHAR_W-1:0] CHAR_P = 8'h50;  // 'P'

  localparam logic [RADIX_W-1:0] RADIX_MIN  = 5'd2;
  localparam logic [RADIX_W-1:0] RADIX_MAX  = 5'd25;
  localparam logic [RADIX_W-1:0] DEC_DIGITS = 5'd10;

  localparam logic [RADIX_W-1:0] RADIX_FROM_RESET = 5'd10;
  localparam logic [RADIX_W-1:0] RADIX_TO_RESET   = 5'd2;

  // configuration register indexes
  localparam logic REG_FROM_BASE = 1'b0;
  localparam logic REG_TO_BASE   = 1'b1;

  localparam logic [STAT_W-1:0] STATUS_OK       = 2'd0;
  localparam logic [STAT_W-1:0] STATUS_BAD      = 2'd1;
  localparam logic [STAT_W-1:0] STATUS_OVERFLOW = 2'd2;

  typedef struct packed {
    logic               ok;
    logic [RADIX_W-1:0] val;
  } digit_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

  function automatic logic [RADIX_W-1:0] clamp_radix(input logic [RADIX_W-1:0] r);
    if (r < RADIX_MIN) begin
      return RADIX_MIN;
    end else if (r > RADIX_MAX) begin
      return RADIX_MAX;
    end
    return r;
  endfunction

  function automatic digit_t decode_char(input logic [CHAR_W-1:0] c);
    digit_t d;
    d.ok  = 1'b0;
    d.val = '0;
    if (c >= CHAR_0 && c <= CHAR_9) begin
      d.ok  = 1'b1;
      d.val = RADIX_W'(c - CHAR_0);
    end else if (c >= CHAR_A && c <= CHAR_P) begin
      d.ok  = 1'b1;
      d.val = RADIX_W'(c - CHAR_A) + DEC_DIGITS;
    end
    return d;
  endfunction

  function automatic logic [CHAR_W-1:0] encode_digit(input logic [RADIX_W-1:0] d);
    if (d < DEC_DIGITS) begin
      return CHAR_0 + CHAR_W'(d);
    end
    return CHAR_A + CHAR_W'(d - DEC_DIGITS);
  endfunction

endpackage

>>> hdl/rc_if.sv
interface rc_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_char;
  logic       in_last;

  modport source (output valid, output in_char, output in_last, input ready);
  modport sink   (input valid, input in_char, input in_last, output ready);
endinterface

interface rc_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_char;
  logic       out_last;
  logic [1:0] status;

  modport source (output valid, output out_char, output out_last, output status,
                  input ready);
  modport sink   (input valid, input out_char, input out_last, input status,
                  output ready);
endinterface

interface rc_cfg_if;
  logic       valid;
  logic       ready;
  logic       index;
  logic [4:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

>>> hdl/radix_converter.sv
// Radix converter.
// in_chan carries one ASCII digit (0-9, A-P) per transfer, most significant
// first, with in_last on the final character. cfg_chan writes from_base
// (index 0) and to_base (index 1); write only while the block is idle.
// out_chan returns the number's digits in to_base, most significant first,
// out_last on the final one; a bad digit or overflow gives a single result
// with status set, out_char 0 and out_last 1.
// On the last character each output digit is found in the shared
// shift-subtract divider (one quotient bit per cycle) and pushed on a stack
// RAM. The digits are then popped: each is read from the stack RAM, then
// written to the output register once that register is free.
// in_chan.ready is low from the last character until its final result is in
// the output register; that register lets the next number's characters be
// taken while the final result still waits. A stalled receiver holds the
// pop sequence. Reset clears the run state, the flags and the output valid,
// and restores from_base to 10 and to_base to 2. cfg_chan is always ready.
module radix_converter #(
  parameter int VALUE_BITS = 31
) (
  input logic   clk,
  input logic   rst_n,
  rc_in_if.sink   in_chan,
  rc_out_if.source out_chan,
  rc_cfg_if.sink  cfg_chan
);
  import rc_pkg::*;

  localparam int PROD_W  = VALUE_BITS + RADIX_W;
  localparam int DEPTH_W = $clog2(VALUE_BITS + 1);
  localparam int ADDR_W  = $clog2(VALUE_BITS);

  typedef enum logic [2:0] {S_IDLE, S_DIV, S_RD, S_EMIT, S_ERR} state_t;

  state_t                state_r, state_nxt;
  logic [VALUE_BITS-1:0] accum_r, accum_nxt;
  logic                  bad_r, bad_nxt;
  logic                  ovf_r, ovf_nxt;
  logic [STAT_W-1:0]     err_status_r, err_status_nxt;
  logic [DEPTH_W-1:0]    depth_r, depth_nxt;
  logic                  out_valid_r, out_valid_nxt;
  logic [CHAR_W-1:0]     out_char_r, out_char_nxt;
  logic                  out_last_r, out_last_nxt;
  logic [STAT_W-1:0]     out_status_r, out_status_nxt;
  logic [RADIX_W-1:0]    from_base_r, from_base_nxt;
  logic [RADIX_W-1:0]    to_base_r, to_base_nxt;

  // Horner step
  logic [RADIX_W-1:0]    fb;
  digit_t                dig;
  logic                  bad_now;
  logic [PROD_W-1:0]     prod;
  logic                  ovf_now;
  logic [VALUE_BITS-1:0] acc_step;
  logic                  bad_step;
  logic                  ovf_step;

  logic                  in_fire;
  logic                  out_free;

  div_stat_t             div_stat;
  logic                  div_start;
  logic [VALUE_BITS-1:0] div_dividend;
  logic [VALUE_BITS-1:0] div_quot;
  logic [RADIX_W-1:0]    div_rem;

  logic                  ram_we;
  logic                  ram_re;
  logic [ADDR_W-1:0]     ram_raddr;
  logic [RADIX_W-1:0]    ram_rdata;

  assign fb      = clamp_radix(from_base_r);
  assign dig     = decode_char(in_chan.in_char);
  assign bad_now = !dig.ok || (dig.val >= fb);
  assign prod    = PROD_W'(accum_r) * PROD_W'(fb) + PROD_W'(dig.val);
  assign ovf_now = prod[PROD_W-1:VALUE_BITS] != '0;

  always_comb begin
    bad_step = bad_r | bad_now;
    ovf_step = ovf_r;
    acc_step = accum_r;
    if (!bad_now && !bad_r && !ovf_r) begin
      if (ovf_now) begin
        ovf_step = 1'b1;
      end else begin
        acc_step = prod[VALUE_BITS-1:0];
      end
    end
  end

  assign in_fire  = in_chan.valid && in_chan.ready;
  assign out_free = !out_valid_r || out_chan.ready;

  always_comb begin
    state_nxt      = state_r;
    accum_nxt      = accum_r;
    bad_nxt        = bad_r;
    ovf_nxt        = ovf_r;
    err_status_nxt = err_status_r;
    depth_nxt      = depth_r;
    out_valid_nxt  = out_valid_r && !out_chan.ready;
    out_char_nxt   = out_char_r;
    out_last_nxt   = out_last_r;
    out_status_nxt = out_status_r;
    from_base_nxt  = from_base_r;
    to_base_nxt    = to_base_r;
    div_start      = 1'b0;
    div_dividend   = accum_r;
    ram_we         = 1'b0;
    ram_re         = 1'b0;
    ram_raddr      = ADDR_W'(depth_r - 1'b1);

    if (cfg_chan.valid) begin
      if (cfg_chan.index == REG_FROM_BASE) begin
        from_base_nxt = cfg_chan.data;
      end else begin
        to_base_nxt = cfg_chan.data;
      end
    end

    case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          if (in_chan.in_last) begin
            // run ends: clear run state; if no error, the divider takes the value
            accum_nxt = '0;
            bad_nxt   = 1'b0;
            ovf_nxt   = 1'b0;
            if (bad_step || ovf_step) begin
              err_status_nxt = bad_step ? STATUS_BAD : STATUS_OVERFLOW;
              state_nxt      = S_ERR;
            end else begin
              div_start    = 1'b1;
              div_dividend = acc_step;
              depth_nxt    = '0;
              state_nxt    = S_DIV;
            end
          end else begin
            accum_nxt = acc_step;
            bad_nxt   = bad_step;
            ovf_nxt   = ovf_step;
          end
        end
      end
      S_DIV: begin
        if (div_stat.done) begin
          ram_we    = 1'b1;
          depth_nxt = depth_r + 1'b1;
          if (div_quot == '0 || depth_r == DEPTH_W'(VALUE_BITS - 1)) begin
            state_nxt = S_RD;
          end else begin
            div_start    = 1'b1;
            div_dividend = div_quot;
          end
        end
      end
      S_RD: begin
        ram_re    = 1'b1;
        state_nxt = S_EMIT;
      end
      S_EMIT: begin
        if (out_free) begin
          out_valid_nxt  = 1'b1;
          out_char_nxt   = encode_digit(ram_rdata);
          out_last_nxt   = depth_r == DEPTH_W'(1);
          out_status_nxt = STATUS_OK;
          depth_nxt      = depth_r - 1'b1;
          state_nxt      = (depth_r == DEPTH_W'(1)) ? S_IDLE : S_RD;
        end
      end
      S_ERR: begin
        if (out_free) begin
          out_valid_nxt  = 1'b1;
          out_char_nxt   = '0;
          out_last_nxt   = 1'b1;
          out_status_nxt = err_status_r;
          state_nxt      = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      accum_r     <= '0;
      bad_r       <= 1'b0;
      ovf_r       <= 1'b0;
      depth_r     <= '0;
      out_valid_r <= 1'b0;
      from_base_r <= RADIX_FROM_RESET;
      to_base_r   <= RADIX_TO_RESET;
    end else begin
      state_r     <= state_nxt;
      accum_r     <= accum_nxt;
      bad_r       <= bad_nxt;
      ovf_r       <= ovf_nxt;
      depth_r     <= depth_nxt;
      out_valid_r <= out_valid_nxt;
      from_base_r <= from_base_nxt;
      to_base_r   <= to_base_nxt;
    end
    err_status_r <= err_status_nxt;
    out_char_r   <= out_char_nxt;
    out_last_r   <= out_last_nxt;
    out_status_r <= out_status_nxt;
  end

  rc_divider #(
    .VALUE_BITS (VALUE_BITS)
  ) u_divider (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (clamp_radix(to_base_r)),
    .stat     (div_stat),
    .quot     (div_quot),
    .rem      (div_rem)
  );

  rc_ram #(
    .WIDTH (RADIX_W),
    .DEPTH (VALUE_BITS)
  ) u_stack (
    .clk   (clk),
    .we    (ram_we),
    .waddr (depth_r[ADDR_W-1:0]),
    .wdata (div_rem),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign in_chan.ready     = state_r == S_IDLE;
  assign cfg_chan.ready    = 1'b1;
  assign out_chan.valid    = out_valid_r;
  assign out_chan.out_char = out_char_r;
  assign out_chan.out_last = out_last_r;
  assign out_chan.status   = out_status_r;

  a_ready_not_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_chan.ready |-> !div_stat.busy && !div_stat.done)
    else $error("input ready while divider is working");

  a_done_in_div: assert property (@(posedge clk) disable iff (!rst_n)
    div_stat.done |-> state_r == S_DIV)
    else $error("divider result arrived outside the divide phase");

  a_depth_bound: assert property (@(posedge clk) disable iff (!rst_n)
    depth_r <= DEPTH_W'(VALUE_BITS))
    else $error("digit stack depth out of range");

  a_error_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_chan.valid && out_chan.status != STATUS_OK |->
      out_chan.out_last && out_chan.out_char == '0)
    else $error("error result not marked final");

  a_emit_pops: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_EMIT && out_free |=> depth_r == $past(depth_r) - 1'b1)
    else $error("digit emitted without pop");

endmodule

>>> hdl/rc_ram.sv
module rc_ram #(
  parameter int WIDTH = 5,
  parameter int DEPTH = 31
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

>>> hdl/rc_divider.sv
module rc_divider #(
  parameter int VALUE_BITS = 31
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  input  logic [VALUE_BITS-1:0]        dividend,
  input  logic [rc_pkg::RADIX_W-1:0]   divisor,
  output rc_pkg::div_stat_t            stat,
  output logic [VALUE_BITS-1:0]        quot,
  output logic [rc_pkg::RADIX_W-1:0]   rem
);
  import rc_pkg::*;

  localparam int CNT_W = $clog2(VALUE_BITS + 1);

  logic [VALUE_BITS-1:0] quot_r, quot_nxt;
  logic [RADIX_W-1:0]    rem_r, rem_nxt;
  logic [RADIX_W-1:0]    div_r, div_nxt;
  logic [CNT_W-1:0]      cnt_r, cnt_nxt;
  logic                  busy_r, busy_nxt;
  logic                  done_r, done_nxt;

  logic [RADIX_W:0] shifted;
  logic [RADIX_W:0] diff;
  logic             ge;

  // one restoring step: shift in the next dividend bit, subtract if it fits
  assign shifted = {rem_r, quot_r[VALUE_BITS-1]};
  assign diff    = shifted - {1'b0, div_r};
  assign ge      = shifted >= {1'b0, div_r};

  always_comb begin
    quot_nxt = quot_r;
    rem_nxt  = rem_r;
    div_nxt  = div_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (start && !busy_r) begin
      quot_nxt = dividend;
      rem_nxt  = '0;
      div_nxt  = divisor;
      cnt_nxt  = CNT_W'(VALUE_BITS);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      quot_nxt = {quot_r[VALUE_BITS-2:0], ge};
      rem_nxt  = ge ? diff[RADIX_W-1:0] : shifted[RADIX_W-1:0];
      cnt_nxt  = cnt_r - 1'b1;
      if (cnt_r == CNT_W'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    quot_r <= quot_nxt;
    rem_r  <= rem_nxt;
    div_r  <= div_nxt;
  end

  assign stat.busy = busy_r;
  assign stat.done = done_r;
  assign quot      = quot_r;
  assign rem       = rem_r;

endmodule

>>> tb/testbench.sv
module testbench;
  import rc_pkg::*;

  localparam int VALUE_BITS = 31;
  localparam logic [63:0] VALUE_MAX = (64'd1 << VALUE_BITS) - 64'd1;
  localparam int SETTLE_CYCLES = 2 * (VALUE_BITS + 3);
  localparam int STALL_LIMIT = 5000;
  localparam int PHASE_ITEMS = 51;

  typedef enum int {IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH} idle_mode_t;

  typedef struct {
    logic [CHAR_W-1:0] ch;
    logic              last;
  } char_item_t;

  typedef struct {
    logic [CHAR_W-1:0] ch;
    logic              last;
    logic [STAT_W-1:0] status;
  } out_digit_t;

  logic clk;
  logic rst_n;

  rc_in_if  in_if ();
  rc_out_if out_if ();
  rc_cfg_if cfg_if ();

  radix_converter #(.VALUE_BITS(VALUE_BITS)) DUT (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_if),
    .out_chan (out_if),
    .cfg_chan (cfg_if)
  );

  char_item_t char_queue[$];
  out_digit_t digits_due[$];
  out_digit_t due_digit;
  idle_mode_t idle_mode = IDLE_NONE;
  bit         in_taken = 1'b0;
  int         errors = 0;
  int         stuck_cycles = 0;

  // converter state as seen from outside
  logic [RADIX_W-1:0] from_reg = RADIX_FROM_RESET;
  logic [RADIX_W-1:0] to_reg   = RADIX_TO_RESET;
  logic [63:0]        acc      = '0;
  logic               bad_seen = 1'b0;
  logic               ovf_seen = 1'b0;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  function automatic logic [63:0] radix_eff(input logic [RADIX_W-1:0] r);
    if (r < RADIX_MIN) begin
      return 64'(RADIX_MIN);
    end else if (r > RADIX_MAX) begin
      return 64'(RADIX_MAX);
    end
    return 64'(r);
  endfunction

  function automatic logic [CHAR_W-1:0] digit_char(input int d);
    if (d < 10) begin
      return CHAR_0 + CHAR_W'(d);
    end
    return CHAR_A + CHAR_W'(d - 10);
  endfunction

  function automatic bit stall(input int pct);
    return $urandom_range(0, 99) < pct;
  endfunction

  function automatic int send_idle_pct();
    if (idle_mode == IDLE_SEND) begin
      return 53;
    end else if (idle_mode == IDLE_BOTH) begin
      return 11;
    end
    return 0;
  endfunction

  function automatic int recv_stall_pct();
    if (idle_mode == IDLE_RECV) begin
      return 53;
    end else if (idle_mode == IDLE_BOTH) begin
      return 11;
    end
    return 0;
  endfunction

  // Horner step on one character; on the last one queue the digits in to_base, or the error result
  task automatic convert_char(input logic [CHAR_W-1:0] c, input logic last);
    logic [63:0] fb;
    logic [63:0] tb;
    logic [63:0] v;
    logic [63:0] d;
    logic        ok;
    int          rems[$];
    out_digit_t  r;
    fb = radix_eff(from_reg);
    ok = 1'b1;
    d  = '0;
    if (c >= CHAR_0 && c <= CHAR_9) begin
      d = 64'(c - CHAR_0);
    end else if (c >= CHAR_A && c <= CHAR_P) begin
      d = 64'(c - CHAR_A) + 64'(DEC_DIGITS);
    end else begin
      ok = 1'b0;
    end
    if (!ok || d >= fb) begin
      bad_seen = 1'b1;
    end else if (!bad_seen && !ovf_seen) begin
      // keep the old value on overflow
      if (acc > (VALUE_MAX - d) / fb) begin
        ovf_seen = 1'b1;
      end else begin
        acc = acc * fb + d;
      end
    end
    if (last) begin
      if (bad_seen || ovf_seen) begin
        r.ch     = '0;
        r.last   = 1'b1;
        r.status = bad_seen ? STATUS_BAD : STATUS_OVERFLOW;
        digits_due.push_back(r);
      end else begin
        tb = radix_eff(to_reg);
        v  = acc;
        do begin
          rems.push_front(int'(v % tb));
          v = v / tb;
        end while (v != 0);
        foreach (rems[i]) begin
          r.ch     = digit_char(rems[i]);
          r.last   = (i == rems.size() - 1);
          r.status = STATUS_OK;
          digits_due.push_back(r);
        end
      end
      acc      = '0;
      bad_seen = 1'b0;
      ovf_seen = 1'b0;
    end
  endtask

  task automatic add_char(input logic [CHAR_W-1:0] c, input logic last);
    char_item_t item;
    item.ch   = c;
    item.last = last;
    char_queue.push_back(item);
  endtask

  task automatic add_text(input string s);
    for (int i = 0; i < s.len(); i++) begin
      add_char(CHAR_W'(s[i]), i == s.len() - 1);
    end
  endtask

  // mostly well-formed numbers; some near the value width, some broken, some noise
  task automatic add_random_number(input int fb, inout int count);
    int                kind;
    int                len;
    int                fit;
    int                bad_at;
    logic [63:0]       span;
    logic [CHAR_W-1:0] c;
    kind = $urandom_range(0, 99);
    fit  = 0;
    span = 64'd1;
    while (span * fb <= VALUE_MAX) begin
      span = span * fb;
      fit++;
    end
    if (kind < 20) begin
      len = $urandom_range(fit, fit + 1);
    end else begin
      len = $urandom_range(1, 5);
    end
    bad_at = (kind >= 75 && kind < 90) ? $urandom_range(0, len - 1) : -1;
    for (int i = 0; i < len; i++) begin
      if (kind >= 90) begin
        c = CHAR_W'($urandom_range(0, 255));
      end else if (i == bad_at) begin
        c = $urandom_range(0, 1) ? digit_char($urandom_range(fb, 25))
                                 : CHAR_W'($urandom_range(0, 255));
      end else begin
        c = digit_char($urandom_range(0, fb - 1));
      end
      add_char(c, i == len - 1);
      count++;
    end
  endtask

  task automatic write_reg(input logic idx, input logic [RADIX_W-1:0] val);
    @(negedge clk);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data  <= val;
    do @(posedge clk); while (!cfg_if.ready);
    if (idx == REG_FROM_BASE) begin
      from_reg = val;
    end else begin
      to_reg = val;
    end
    @(negedge clk);
    cfg_if.valid <= 1'b0;
  endtask

  // drain everything, then let the divider go quiet
  task automatic finish_phase();
    while (char_queue.size() != 0) @(posedge clk);
    while (digits_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  always @(negedge clk) begin
    if (!rst_n) begin
      in_if.valid <= 1'b0;
    end else if (in_if.valid && !in_taken) begin
      // hold until the transfer completes
    end else if (char_queue.size() != 0 && !stall(send_idle_pct())) begin
      in_if.valid   <= 1'b1;
      in_if.in_char <= char_queue[0].ch;
      in_if.in_last <= char_queue[0].last;
    end else begin
      in_if.valid <= 1'b0;
    end
    in_taken = 1'b0;
    out_if.ready <= !stall(recv_stall_pct());
  end

  always @(posedge clk) begin
    if (in_if.valid && in_if.ready) begin
      in_taken = 1'b1;
      convert_char(char_queue[0].ch, char_queue[0].last);
      void'(char_queue.pop_front());
    end
  end

  always @(posedge clk) begin
    if (out_if.valid && out_if.ready) begin
      if (digits_due.size() == 0) begin
        $display("%0t: unexpected result char %h last %b status %0d", $time,
                 out_if.out_char, out_if.out_last, out_if.status);
        errors++;
      end else begin
        due_digit = digits_due.pop_front();
        if (due_digit.ch !== out_if.out_char || due_digit.last !== out_if.out_last ||
            due_digit.status !== out_if.status) begin
          $display("%0t: expected char %h last %b status %0d, got char %h last %b status %0d",
                   $time, due_digit.ch, due_digit.last, due_digit.status,
                   out_if.out_char, out_if.out_last, out_if.status);
          errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready) ||
        (cfg_if.valid && cfg_if.ready)) begin
      stuck_cycles <= 0;
    end else begin
      stuck_cycles <= stuck_cycles + 1;
    end
  end

  initial begin
    wait (stuck_cycles >= STALL_LIMIT);
    $display("testbench NOT OK");
    $finish;
  end

  initial begin
    int                 count;
    logic [RADIX_W-1:0] from_val;
    logic [RADIX_W-1:0] to_val;
    in_if.valid   = 1'b0;
    in_if.in_char = '0;
    in_if.in_last = 1'b0;
    out_if.ready  = 1'b0;
    cfg_if.valid  = 1'b0;
    cfg_if.index  = REG_FROM_BASE;
    cfg_if.data   = '0;
    rst_n         = 1'b0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // reset radices: zero, non-digit, digit not below base, largest value
    add_text("0");
    add_text("a");
    add_text("A");
    add_text("2147483647");
    finish_phase();

    // top radix: largest digit, digit equal to base, overflow then bad digit
    write_reg(REG_FROM_BASE, RADIX_MAX);
    write_reg(REG_TO_BASE, RADIX_MAX);
    add_text("O");
    add_text("P");
    add_text("OOOOOOO@");
    finish_phase();

    for (int p = 0; p < 8; p++) begin
      case (p)
        0: begin
          from_val = 5'd2;
          to_val   = 5'd25;
        end
        1: begin
          from_val = 5'd25;
          to_val   = 5'd2;
        end
        2: begin
          from_val = 5'd16;
          to_val   = 5'd10;
        end
        3: begin
          // out-of-range values clamp to the nearest radix
          from_val = 5'd0;
          to_val   = 5'd31;
        end
        4: begin
          from_val = 5'd31;
          to_val   = 5'd1;
        end
        default: begin
          from_val = RADIX_W'($urandom_range(0, 31));
          to_val   = RADIX_W'($urandom_range(0, 31));
        end
      endcase
      write_reg(REG_FROM_BASE, from_val);
      write_reg(REG_TO_BASE, to_val);
      idle_mode = idle_mode_t'(p % 4);
      count = 0;
      while (count < PHASE_ITEMS) begin
        add_random_number(int'(radix_eff(from_val)), count);
      end
      finish_phase();
    end

    if (errors == 0 && digits_due.size() == 0) begin
      $display("testbench OK");
    end else begin
      $display("testbench NOT OK");
    end
    $finish;
  end

endmodule
